>>> sv/bb3_pkg.sv
`default_nettype none
package bb3_pkg;

   typedef logic [23:0] pixel_type;

   // Register indexes of the configuration port
   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_READ,
      FRONT_EXEC
   } front_state_type;

   // One averaging job: window column 0 is oldest, row 0 is top
   typedef struct packed {
      pixel_type [8:0] win;
      logic [1:0]      col_lo;
      logic [1:0]      row_lo;
      logic [1:0]      row_hi;
      logic            last;
   } job_type;

   localparam int RECIP_SHIFT = 17;

   // ceil(2^17 / (2*n)) for the pixel counts that can occur
   function automatic logic [16:0] recip(input logic [3:0] n);
      logic [16:0] m;
      case (n)
         4'd1:    m = 17'd65536;
         4'd2:    m = 17'd32768;
         4'd3:    m = 17'd21846;
         4'd4:    m = 17'd16384;
         4'd6:    m = 17'd10923;
         4'd9:    m = 17'd7282;
         default: m = 17'd65536;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

>>> sv/bb3_queue.sv
`default_nettype none
module bb3_queue import bb3_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_en,
   input  wire job_type wr_job,
   output logic         q_full,
   input  wire logic    rd_en,
   output job_type      rd_job,
   output logic         q_valid
);

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_en ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rd_en ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(wr_en) - 2'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_job;
      end
   end

   assign rd_job  = slot_ff[rd_ptr_ff];
   assign q_valid = (count_ff != 2'd0);
   assign q_full  = (count_ff == 2'd2);

endmodule
`default_nettype wire

>>> sv/bb3_front.sv
`default_nettype none
module bb3_front import bb3_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_mode,
   input  wire logic [7:0]  req_in_red,
   input  wire logic [7:0]  req_in_green,
   input  wire logic [7:0]  req_in_blue,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [12:0] csr_wdata,
   output logic             q_push,
   output job_type          q_job,
   input  wire logic        q_full
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = $clog2(MAX_HEIGHT + 2);

   front_state_type state_ff, state_in;

   logic [10:0]   width_ff;
   logic [12:0]   height_ff;
   logic [CW-1:0] col_ff, col_in, ocol_ff, ocol_in;
   logic [RW-1:0] row_ff, row_in, orow_ff, orow_in;
   pixel_type     win_ff [9];
   pixel_type     sh [9];
   pixel_type     px_ff;
   logic          flush_ff, eff_ff, retry_ff;
   logic [47:0]   rd_ff;
   logic [47:0]   line_mem [MAX_WIDTH];

   logic          accept, eff, rd_en, exec, produce, last;
   logic [CW-1:0] w_eff;
   logic [RW-1:0] h_eff;
   logic [AW-1:0] addr;

   always_comb begin
      if (width_ff == 11'd0) begin
         w_eff = CW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(width_ff);
      end
      if (height_ff == 13'd0) begin
         h_eff = RW'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = RW'(MAX_HEIGHT);
      end else begin
         h_eff = RW'(height_ff);
      end
   end

   assign addr   = col_ff[AW-1:0];
   assign full   = (state_ff != FRONT_IDLE) || q_full;
   assign accept = push && !full;
   assign eff    = req_mode ? (32'(row_ff) >= 32'(h_eff)) : (32'(row_ff) < 32'(h_eff));

   // next state
   always_comb begin
      case (state_ff)
         FRONT_IDLE: state_in = accept ? FRONT_EXEC : FRONT_IDLE;
         FRONT_READ: state_in = FRONT_EXEC;
         FRONT_EXEC: begin
            if (eff_ff && flush_ff && !produce && !retry_ff) begin
               state_in = FRONT_READ;
            end else begin
               state_in = FRONT_IDLE;
            end
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      case (state_ff)
         FRONT_IDLE: begin
            rd_en = accept;
            exec  = 1'b0;
         end
         FRONT_READ: begin
            rd_en = 1'b1;
            exec  = 1'b0;
         end
         FRONT_EXEC: begin
            rd_en = 1'b0;
            exec  = eff_ff;
         end
         default: begin
            rd_en = 1'b0;
            exec  = 1'b0;
         end
      endcase
   end

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         sh[k] = win_ff[k + 3];
      end
      sh[6] = rd_ff[47:24];
      sh[7] = rd_ff[23:0];
      sh[8] = px_ff;

      produce = (32'(row_ff) >= 2) || ((32'(row_ff) == 1) && (32'(col_ff) >= 1));
      last    = (32'(orow_ff) + 1 >= 32'(h_eff)) && (32'(ocol_ff) + 1 >= 32'(w_eff));

      for (int k = 0; k < 9; k++) begin
         q_job.win[k] = (col_ff == '0) ? win_ff[k] : sh[k];
      end
      if (col_ff == '0) begin
         q_job.col_lo = (32'(w_eff) >= 2) ? 2'd1 : 2'd2;
      end else begin
         q_job.col_lo = (32'(col_ff) >= 2) ? 2'd0 : 2'd1;
      end
      q_job.row_lo = (32'(orow_ff) >= 1) ? 2'd0 : 2'd1;
      q_job.row_hi = (32'(orow_ff) + 1 < 32'(h_eff)) ? 2'd2 : 2'd1;
      q_job.last   = last;
      q_push       = exec && produce;

      // advance input and output positions
      col_in  = col_ff;
      row_in  = row_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      if (exec) begin
         if (32'(col_ff) + 1 >= 32'(w_eff)) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
         if (produce) begin
            if (last) begin
               col_in  = '0;
               row_in  = '0;
               ocol_in = '0;
               orow_in = '0;
            end else if (32'(ocol_ff) + 1 >= 32'(w_eff)) begin
               ocol_in = '0;
               orow_in = orow_ff + RW'(1);
            end else begin
               ocol_in = ocol_ff + CW'(1);
            end
         end
      end
      // any register write restarts the stream
      if (csr_wr_en) begin
         col_in  = '0;
         row_in  = '0;
         ocol_in = '0;
         orow_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FRONT_IDLE;
         width_ff  <= 11'd1024;
         height_ff <= 13'd1024;
         col_ff    <= '0;
         row_ff    <= '0;
         ocol_ff   <= '0;
         orow_ff   <= '0;
         retry_ff  <= 1'b0;
         eff_ff    <= 1'b0;
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         ocol_ff  <= ocol_in;
         orow_ff  <= orow_in;
         if (accept) begin
            eff_ff   <= eff;
            retry_ff <= 1'b0;
         end else if (state_ff == FRONT_READ) begin
            retry_ff <= 1'b1;
         end
         if (exec) begin
            for (int k = 0; k < 9; k++) begin
               win_ff[k] <= sh[k];
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[10:0];
               CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // a flush shifts in a zero pixel
   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff    <= req_mode ? '0 : {req_in_red, req_in_green, req_in_blue};
         flush_ff <= req_mode;
      end else if (state_ff == FRONT_READ) begin
         px_ff <= '0;
      end
   end

   // line stores: upper half holds the older row, lower half the newer
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= line_mem[addr];
      end
      if (exec) begin
         line_mem[addr] <= {rd_ff[23:0], px_ff};
      end
   end

endmodule
`default_nettype wire

>>> sv/bb3_back.sv
`default_nettype none
module bb3_back import bb3_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   input  wire job_type job,
   output logic         job_pop,
   output logic         empty,
   input  wire logic    pop,
   output logic [7:0]   rsp_out_red,
   output logic [7:0]   rsp_out_green,
   output logic [7:0]   rsp_out_blue,
   output logic         rsp_frame_end
);

   logic        v1_ff, v2_ff, last1_ff, last2_ff;
   logic [12:0] x_ff [3];
   logic [12:0] x_in [3];
   logic [16:0] m_ff, m_in;
   logic [29:0] prod_ff [3];
   logic [11:0] sum [3];
   logic [3:0]  count;
   logic        take, adv1, adv2;
   pixel_type   px;

   assign take    = pop && v2_ff;
   assign adv2    = v1_ff && (!v2_ff || take);
   assign adv1    = job_valid && (!v1_ff || adv2);
   assign job_pop = adv1;

   // add up the in-image pixels of the window
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum[ch] = '0;
      end
      count = '0;
      px    = '0;
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            if ((2'(c) >= job.col_lo) && (2'(r) >= job.row_lo) && (2'(r) <= job.row_hi)) begin
               px      = job.win[c * 3 + r];
               sum[0]  = sum[0] + 12'(px[23:16]);
               sum[1]  = sum[1] + 12'(px[15:8]);
               sum[2]  = sum[2] + 12'(px[7:0]);
               count   = count + 4'd1;
            end
         end
      end
      for (int ch = 0; ch < 3; ch++) begin
         x_in[ch] = {sum[ch], 1'b0} + 13'(count);
      end
      m_in = recip(count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= 1'b1;
         end else if (adv2) begin
            v1_ff <= 1'b0;
         end
         if (adv2) begin
            v2_ff <= 1'b1;
         end else if (take) begin
            v2_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         x_ff     <= x_in;
         m_ff     <= m_in;
         last1_ff <= job.last;
      end
      if (adv2) begin
         for (int ch = 0; ch < 3; ch++) begin
            prod_ff[ch] <= 30'(x_ff[ch]) * 30'(m_ff);
         end
         last2_ff <= last1_ff;
      end
   end

   assign empty         = !v2_ff;
   assign rsp_out_red   = prod_ff[0][RECIP_SHIFT +: 8];
   assign rsp_out_green = prod_ff[1][RECIP_SHIFT +: 8];
   assign rsp_out_blue  = prod_ff[2][RECIP_SHIFT +: 8];
   assign rsp_frame_end = last2_ff;

endmodule
`default_nettype wire

>>> sv/box_blur_3x3_edge_aware_unit.sv
// Each accepted item passes through the front as a line store read, then a
// read-modify-write of the same entry; a flush that needs a second advance does both again.
// A result goes through the two-entry queue and the back's sum and product registers
// before it shows on the result ports; pixel results trail their input by
// image_width+1 items. The front takes no new item until it is done with the last one.
// Reset (synchronous, active high) clears counters, window, queues and sizes to 1024x1024.
// Line store contents are not cleared.
`default_nettype none
module box_blur_3x3_edge_aware_unit import bb3_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_mode,
   input  wire logic [7:0]  req_in_red,
   input  wire logic [7:0]  req_in_green,
   input  wire logic [7:0]  req_in_blue,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_out_red,
   output logic [7:0]       rsp_out_green,
   output logic [7:0]       rsp_out_blue,
   output logic             rsp_frame_end,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [12:0] csr_wdata
);

   // front -> queue -> back transfer
   logic    q_push, q_full, q_valid, q_pop;
   job_type q_wr_job, q_rd_job;

   // Front: classify items, walk the line stores and window, build jobs
   bb3_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_mode     (req_mode),
      .req_in_red   (req_in_red),
      .req_in_green (req_in_green),
      .req_in_blue  (req_in_blue),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_push       (q_push),
      .q_job        (q_wr_job),
      .q_full       (q_full)
   );

   // Two-entry queue lets front and back stall on their own
   bb3_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_job  (q_wr_job),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .rd_job  (q_rd_job),
      .q_valid (q_valid)
   );

   // Back: sum, multiply by reciprocal of 2*count, hold result until popped
   bb3_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (q_valid),
      .job           (q_rd_job),
      .job_pop       (q_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
`default_nettype wire

>>> sv/bb3_checker.sv
`default_nettype none
module bb3_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       push,
   input wire logic       full,
   input wire logic       empty,
   input wire logic       pop,
   input wire logic [7:0] rsp_out_red,
   input wire logic [7:0] rsp_out_green,
   input wire logic [7:0] rsp_out_blue,
   input wire logic       rsp_frame_end
);

   // come out of reset idle with nothing pending
   a_reset_idle: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("not idle after reset");

   // every transfer in occupies the front for the next cycle
   a_busy_after_push: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> full)
      else $error("item accepted back to back");

   // a pending result holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_red) && $stable(rsp_out_green)
                             && $stable(rsp_out_blue) && $stable(rsp_frame_end)))
      else $error("result changed while stalled");

endmodule

bind box_blur_3x3_edge_aware_unit bb3_checker u_bb3_checker (.*);
`default_nettype wire
